// ===== rtl/fsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types and constants for the FASTA sequence packer.
// ----------------------------------------------------------------------------
package fsp_pkg;

    localparam int COUNT_BITS_DEFAULT = 32;

    // result queue depth, power of two, at least 2
    localparam int OUTQ_DEPTH = 4;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_LEAD   = 3'd1;
    localparam logic [2:0] ST_PRINTABLE = 3'd2;
    localparam logic [2:0] ST_NONPRINT  = 3'd3;
    localparam logic [2:0] ST_EMPTY_END = 3'd4;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_HEADER,
        PH_SEQ,
        PH_ERROR
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        run_end;
        logic        file_done;
        logic [2:0]  status;
        logic [31:0] seq_total;
        logic [31:0] letter_total;
        logic [31:0] shortest_len;
        logic [31:0] longest_len;
    } t_out_word;

    // second implies first
    typedef struct packed {
        logic first;
        logic second;
    } t_push;

endpackage

// ===== rtl/fsp_core.sv =====
// ----------------------------------------------------------------------------
// fsp_core
// Input register, parse state and counters; forms up to two result words
// per input word.
// ----------------------------------------------------------------------------
module fsp_core #(
    parameter int COUNT_BITS = fsp_pkg::COUNT_BITS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fsp_pkg::t_in_word i_in_word,
    input  logic              i_room,
    output fsp_pkg::t_push    o_push,
    output fsp_pkg::t_out_word o_res0,
    output fsp_pkg::t_out_word o_res1
);

    localparam int WIDE_BITS = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    logic                   r_in_valid;
    fsp_pkg::t_in_word      r_in_word;
    fsp_pkg::t_phase        r_phase, n_phase, m_phase;
    logic [COUNT_BITS-1:0]  r_cur, n_cur, m_cur;
    logic [COUNT_BITS-1:0]  r_seq, n_seq, m_seq;
    logic [COUNT_BITS-1:0]  r_letter, n_letter, m_letter;
    logic [COUNT_BITS-1:0]  r_min, n_min, m_min;
    logic [COUNT_BITS-1:0]  r_max, n_max, m_max;
    logic [COUNT_BITS-1:0]  fin_min, fin_max;

    logic       fire;
    logic [7:0] b;
    logic       last;
    logic       is_gt, is_nl, is_alpha, is_print;
    logic       f_has, z_has, z_done;
    fsp_pkg::t_out_word f_word, z_word;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [31:0] to_out(input logic [COUNT_BITS-1:0] v);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        to_out = (w > WIDE_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    assign fire       = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || fire;
    assign b          = r_in_word.in_byte;
    assign last       = r_in_word.in_last;

    always_comb begin
        is_gt    = (b == fsp_pkg::CH_GT);
        is_nl    = (b == fsp_pkg::CH_LF) || (b == fsp_pkg::CH_CR);
        is_alpha = b inside {[fsp_pkg::CH_UPPER_A:fsp_pkg::CH_UPPER_Z],
                             [fsp_pkg::CH_LOWER_A:fsp_pkg::CH_LOWER_Z]};
        is_print = b inside {[fsp_pkg::CH_PRINT_LO:fsp_pkg::CH_PRINT_HI]};
    end

    // state after the byte itself, before end-of-file handling
    always_comb begin
        m_phase  = r_phase;
        m_cur    = r_cur;
        m_seq    = r_seq;
        m_letter = r_letter;
        m_min    = r_min;
        m_max    = r_max;
        case (r_phase)
            fsp_pkg::PH_FIRST: begin
                if (is_gt) begin
                    m_seq   = sat_inc(r_seq);
                    m_phase = fsp_pkg::PH_HEADER;
                end else begin
                    m_phase = fsp_pkg::PH_ERROR;
                end
            end
            fsp_pkg::PH_HEADER: begin
                if (is_nl) begin
                    m_phase = fsp_pkg::PH_SEQ;
                end
            end
            fsp_pkg::PH_SEQ: begin
                if (is_gt) begin
                    m_seq   = sat_inc(r_seq);
                    m_min   = (r_cur < r_min) ? r_cur : r_min;
                    m_max   = (r_cur > r_max) ? r_cur : r_max;
                    m_cur   = '0;
                    m_phase = fsp_pkg::PH_HEADER;
                end else if (is_alpha) begin
                    m_cur    = sat_inc(r_cur);
                    m_letter = sat_inc(r_letter);
                end else if (!is_nl) begin
                    m_phase = fsp_pkg::PH_ERROR;
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        if (last) begin
            n_phase  = fsp_pkg::PH_FIRST;
            n_cur    = '0;
            n_seq    = '0;
            n_letter = '0;
            n_min    = '1;
            n_max    = '0;
        end else begin
            n_phase  = m_phase;
            n_cur    = m_cur;
            n_seq    = m_seq;
            n_letter = m_letter;
            n_min    = m_min;
            n_max    = m_max;
        end
    end

    // result words
    always_comb begin
        f_has  = 1'b0;
        f_word = '0;
        f_word.status = fsp_pkg::ST_OK;
        case (r_phase)
            fsp_pkg::PH_FIRST: begin
                if (!is_gt) begin
                    f_has         = 1'b1;
                    f_word.status = fsp_pkg::ST_NO_LEAD;
                end
            end
            fsp_pkg::PH_SEQ: begin
                if (is_gt) begin
                    f_has           = 1'b1;
                    f_word.out_byte = fsp_pkg::CH_DOLLAR;
                end else if (is_alpha) begin
                    f_has           = 1'b1;
                    f_word.out_byte = b;
                end else if (is_nl) begin
                    f_has = 1'b0;
                end else if (is_print) begin
                    f_has         = 1'b1;
                    f_word.status = fsp_pkg::ST_PRINTABLE;
                end else begin
                    f_has         = 1'b1;
                    f_word.status = fsp_pkg::ST_NONPRINT;
                end
            end
            default: begin
            end
        endcase

        z_has   = last && (m_phase != fsp_pkg::PH_ERROR);
        z_done  = (m_cur != '0);
        fin_min = (m_cur < m_min) ? m_cur : m_min;
        fin_max = (m_cur > m_max) ? m_cur : m_max;
        z_word  = '0;
        z_word.run_end = 1'b1;
        if (z_done) begin
            z_word.out_byte     = fsp_pkg::CH_DOLLAR;
            z_word.file_done    = 1'b1;
            z_word.status       = fsp_pkg::ST_OK;
            z_word.seq_total    = to_out(m_seq);
            z_word.letter_total = to_out(m_letter);
            z_word.shortest_len = to_out(fin_min);
            z_word.longest_len  = to_out(fin_max);
        end else begin
            z_word.status = fsp_pkg::ST_EMPTY_END;
        end
        f_word.run_end = !z_has;

        o_push.first  = fire && (f_has || z_has);
        o_push.second = fire && f_has && z_has;
        o_res0        = f_has ? f_word : z_word;
        o_res1        = z_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= fsp_pkg::PH_FIRST;
            r_cur      <= '0;
            r_seq      <= '0;
            r_letter   <= '0;
            r_min      <= '1;
            r_max      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_phase  <= n_phase;
                r_cur    <= n_cur;
                r_seq    <= n_seq;
                r_letter <= n_letter;
                r_min    <= n_min;
                r_max    <= n_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

`ifndef SYNTHESIS
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && last |=> r_phase == fsp_pkg::PH_FIRST && r_cur == '0 && r_seq == '0)
        else $error("state not cleared after last word");
    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.second |-> o_push.first)
        else $error("second result pushed without first");
    a_state_holds: assert property (@(posedge i_clk)
        i_rst_n && !fire |=> $stable(r_phase) && $stable(r_letter))
        else $error("parse state changed without a word");
`endif

endmodule

// ===== rtl/fsp_outq.sv =====
// ----------------------------------------------------------------------------
// fsp_outq
// Result queue: takes up to two words per cycle, one out per ready cycle.
// ----------------------------------------------------------------------------
module fsp_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fsp_pkg::t_push      i_push,
    input  fsp_pkg::t_out_word  i_res0,
    input  fsp_pkg::t_out_word  i_res1,
    output logic                o_room,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fsp_pkg::t_out_word  o_out_word
);

    localparam int DEPTH = fsp_pkg::OUTQ_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fsp_pkg::t_out_word r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   push_n;
    logic               pop;

    assign pop         = (r_count != '0) && i_out_ready;
    assign push_n      = CNT_W'(i_push.first) + CNT_W'(i_push.second);
    assign o_room      = (r_count <= CNT_W'(DEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign o_out_word  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(push_n);
            r_rd    <= r_rd + PTR_W'(pop);
            r_count <= r_count + push_n - CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push.second) begin
            r_mem[r_wr + PTR_W'(1)] <= i_res1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue overflow");
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.first |-> o_room)
        else $error("push without room");
    a_count_idle: assert property (@(posedge i_clk)
        i_rst_n && !i_push.first && !pop |=> $stable(r_count))
        else $error("queue count moved without push or pop");
`endif

endmodule

// ===== rtl/fasta_sequence_packer_unit.sv =====
// ----------------------------------------------------------------------------
// fasta_sequence_packer_unit
// FASTA text to packed letter stream with per-file length summary.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_word): one text byte per word,
// in_last set on the final byte of a file.
// Output channel (o_out_valid / i_out_ready / o_out_word): letters, '$'
// separators, error words and the closing summary of each error-free file.
// A byte gives zero, one or two result words; two only on a last byte that
// also produces a word of its own.
// Path: an accepted byte waits in the input register, then its results are
// written into the result queue, from which they are offered.
// Throughput: one byte per cycle while results are taken as fast; the extra
// result of a byte that gives two is absorbed by the four-entry result queue.
// Reset clears the parse state and counters and empties the queue.
// When the receiver stalls, the queue fills; once fewer than two queue
// entries are free, a held input byte waits and input ready drops.
// ----------------------------------------------------------------------------
module fasta_sequence_packer_unit #(
    parameter int COUNT_BITS = fsp_pkg::COUNT_BITS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fsp_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fsp_pkg::t_out_word o_out_word
);

    fsp_pkg::t_push     push;
    fsp_pkg::t_out_word res0, res1;
    logic               room;

    fsp_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_room     (room),
        .o_push     (push),
        .o_res0     (res0),
        .o_res1     (res1)
    );

    fsp_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_res0      (res0),
        .i_res1      (res1),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
